FILE: design/speed_pi_regulator_prescaled_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the speed PI regulator
// Shared implication forms used by the regulator's checks.
// ----------------------------------------------------------------------------
`ifndef SPEED_PI_REGULATOR_PRESCALED_TOP_ASSERT_SVH
`define SPEED_PI_REGULATOR_PRESCALED_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SPRP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define SPRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: design/sprp_pkg.sv
// ----------------------------------------------------------------------------
// Speed PI regulator package
// Widths, register map, interface structs, microcode and saturation helpers.
// ----------------------------------------------------------------------------
package sprp_pkg;

    localparam int CMD_W   = 2;
    localparam int SPEED_W = 32;
    localparam int ERR_W   = 33;
    localparam int SUM_W   = 34;
    localparam int INT_W   = 48;
    localparam int GAIN_W  = 24;
    localparam int LIM_W   = 31;
    localparam int DIV_W   = 16;
    localparam int HP_W    = 32;
    localparam int KT_W    = 24;
    localparam int OPA_W   = 34;
    localparam int OPB_W   = 48;
    localparam int CHUNK_W = 24;
    localparam int PROD_W  = OPA_W + CHUNK_W;
    localparam int ACC_W   = 72;
    localparam int MAG_W   = 56;
    localparam int SMAG_W  = MAG_W + 1;
    localparam int WIDE_W  = 58;
    localparam int P_W     = 42;
    localparam int CFGI_W  = 3;
    localparam int CFGD_W  = 32;
    localparam int UPC_W   = 5;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd32768;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd983040;
    localparam logic [LIM_W-1:0]  SPEED_LIM_RST  = 31'd26214400;
    localparam logic [DIV_W-1:0]  PRESCALE_RST   = 16'd10;
    localparam logic [HP_W-1:0]   HALF_PER_RST   = 32'd2147484;
    localparam logic [KT_W-1:0]   KT_RST         = 24'd65536;

    localparam logic [ACC_W-1:0] RND32_K = 72'h80000000;
    localparam logic [ACC_W-1:0] RND16_K = 72'h8000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } t_cmd;

    typedef enum logic [CFGI_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_SPEED_LIM  = 3'd2,
        REG_PRESCALE   = 3'd3,
        REG_HALF_PER   = 3'd4,
        REG_KT         = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]        prop_gain;
        logic [GAIN_W-1:0]        integ_gain;
        logic [LIM_W-1:0]         speed_limit;
        logic [DIV_W-1:0]         prescale_div;
        logic [HP_W-1:0]          half_period;
        logic signed [KT_W-1:0]   torque_to_current;
    } t_cfg;

    typedef struct packed {
        logic go;
        logic run;
        logic clr_int;
    } t_core_req;

    typedef struct packed {
        logic idle;
        logic emit;
    } t_core_stat;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_ERR,
        OP_LD_INC,
        OP_MUL,
        OP_RND32,
        OP_RND16,
        OP_INTEG,
        OP_PSAVE,
        OP_TORQ,
        OP_LD_CUR,
        OP_CUR,
        OP_EMIT
    } t_uop;

    typedef enum logic [1:0] {
        UC_NEXT,
        UC_WAIT_GO,
        UC_CHUNK,
        UC_WAIT_OUT
    } t_ucond;

    typedef logic [UPC_W-1:0] t_upc;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_upc   target;
    } t_uword;

    localparam t_upc UPC_IDLE   = 5'd0;
    localparam t_upc UPC_ERR    = 5'd1;
    localparam t_upc UPC_LD_INC = 5'd2;
    localparam t_upc UPC_MUL_I  = 5'd3;
    localparam t_upc UPC_RND_I  = 5'd4;
    localparam t_upc UPC_INTEG  = 5'd5;
    localparam t_upc UPC_MUL_P  = 5'd6;
    localparam t_upc UPC_RND_P  = 5'd7;
    localparam t_upc UPC_PSAVE  = 5'd8;
    localparam t_upc UPC_MUL_K  = 5'd9;
    localparam t_upc UPC_RND_K  = 5'd10;
    localparam t_upc UPC_TORQ   = 5'd11;
    localparam t_upc UPC_LD_CUR = 5'd12;
    localparam t_upc UPC_MUL_C  = 5'd13;
    localparam t_upc UPC_RND_C  = 5'd14;
    localparam t_upc UPC_CUR    = 5'd15;
    localparam t_upc UPC_EMIT   = 5'd16;

    // Control store: one word per step of the regulator program.
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        w = '{op: OP_IDLE, cond: UC_WAIT_GO, target: UPC_EMIT};
        case (pc)
            UPC_IDLE:   w = '{op: OP_IDLE,   cond: UC_WAIT_GO,  target: UPC_EMIT};
            UPC_ERR:    w = '{op: OP_ERR,    cond: UC_NEXT,     target: UPC_IDLE};
            UPC_LD_INC: w = '{op: OP_LD_INC, cond: UC_NEXT,     target: UPC_IDLE};
            UPC_MUL_I:  w = '{op: OP_MUL,    cond: UC_CHUNK,    target: UPC_IDLE};
            UPC_RND_I:  w = '{op: OP_RND32,  cond: UC_NEXT,     target: UPC_IDLE};
            UPC_INTEG:  w = '{op: OP_INTEG,  cond: UC_NEXT,     target: UPC_IDLE};
            UPC_MUL_P:  w = '{op: OP_MUL,    cond: UC_CHUNK,    target: UPC_IDLE};
            UPC_RND_P:  w = '{op: OP_RND16,  cond: UC_NEXT,     target: UPC_IDLE};
            UPC_PSAVE:  w = '{op: OP_PSAVE,  cond: UC_NEXT,     target: UPC_IDLE};
            UPC_MUL_K:  w = '{op: OP_MUL,    cond: UC_CHUNK,    target: UPC_IDLE};
            UPC_RND_K:  w = '{op: OP_RND16,  cond: UC_NEXT,     target: UPC_IDLE};
            UPC_TORQ:   w = '{op: OP_TORQ,   cond: UC_NEXT,     target: UPC_IDLE};
            UPC_LD_CUR: w = '{op: OP_LD_CUR, cond: UC_NEXT,     target: UPC_IDLE};
            UPC_MUL_C:  w = '{op: OP_MUL,    cond: UC_CHUNK,    target: UPC_IDLE};
            UPC_RND_C:  w = '{op: OP_RND16,  cond: UC_NEXT,     target: UPC_IDLE};
            UPC_CUR:    w = '{op: OP_CUR,    cond: UC_NEXT,     target: UPC_IDLE};
            UPC_EMIT:   w = '{op: OP_EMIT,   cond: UC_WAIT_OUT, target: UPC_IDLE};
            default:    w = '{op: OP_IDLE,   cond: UC_WAIT_GO,  target: UPC_EMIT};
        endcase
        return w;
    endfunction

    function automatic logic signed [INT_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
        logic signed [INT_W-1:0] r;
        if (&v[WIDE_W-1:INT_W-1] || ~|v[WIDE_W-1:INT_W-1]) begin
            r = v[INT_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r = {1'b1, {(INT_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(INT_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [SPEED_W-1:0] sat32(input logic signed [SMAG_W-1:0] v);
        logic signed [SPEED_W-1:0] r;
        if (&v[SMAG_W-1:SPEED_W-1] || ~|v[SMAG_W-1:SPEED_W-1]) begin
            r = v[SPEED_W-1:0];
        end else if (v[SMAG_W-1]) begin
            r = {1'b1, {(SPEED_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(SPEED_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: design/speed_pi_regulator_prescaled_top.sv
// ----------------------------------------------------------------------------
// Prescaled PI speed regulator, top level
// Every input beat yields one output beat. A tick advances the prescaler;
// an enabled tick with a pending step runs the PI chain and updates the held
// current reference. Start and stop beats set or clear enable and zero the
// integral. A tick or command that runs no step goes from the idle step
// straight to the emit step; a beat that runs a control step walks the whole
// microcode program, paced by the single shared 34x24 multiplier that forms the
// integral increment and the three gain products in turn, two passes each.
// The output register lets a new beat enter while a result still waits.
// ----------------------------------------------------------------------------
module speed_pi_regulator_prescaled_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [63:0]                         i_s_tdata,   // speed_ref, measured_speed
    input  logic [sprp_pkg::CMD_W-1:0]          i_s_tuser,   // cmd
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [71:0]                         o_m_tdata,   // current_ref, speed_error, zero pad
    output logic [0:0]                          o_m_tuser,   // updated
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sprp_pkg::CFGI_W-1:0]         i_cfg_index,
    input  logic [sprp_pkg::CFGD_W-1:0]         i_cfg_data
);

    sprp_pkg::t_cfg       r_cfg;
    logic                 r_enabled;
    logic [sprp_pkg::DIV_W-1:0] r_tick;
    logic                 r_pending;
    logic                 r_upd;
    logic                 r_out_valid;
    logic                 r_out_upd;
    logic signed [sprp_pkg::SPEED_W-1:0] r_out_cur;
    logic signed [sprp_pkg::ERR_W-1:0]   r_out_err;

    sprp_pkg::t_core_req  w_req;
    sprp_pkg::t_core_stat w_stat;
    sprp_pkg::t_cmd       w_cmd;
    logic                 w_accept;
    logic                 w_out_free;
    logic [sprp_pkg::DIV_W:0] w_tick_next;
    logic                 w_fire;
    logic                 w_pend_after;
    logic                 w_run;
    logic signed [sprp_pkg::SPEED_W-1:0] w_core_cur;
    logic signed [sprp_pkg::ERR_W-1:0]   w_core_err;

    assign w_cmd        = sprp_pkg::t_cmd'(i_s_tuser);
    assign o_s_tready   = w_stat.idle;
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_out_free   = !r_out_valid || i_m_tready;
    assign w_tick_next  = {1'b0, r_tick} + 1'b1;
    assign w_fire       = (w_tick_next >= {1'b0, r_cfg.prescale_div});
    assign w_pend_after = w_fire || r_pending;
    assign w_run        = (w_cmd == sprp_pkg::CMD_TICK) && r_enabled && w_pend_after;

    assign w_req.go      = w_accept;
    assign w_req.run     = w_run;
    assign w_req.clr_int = (w_cmd == sprp_pkg::CMD_START) || (w_cmd == sprp_pkg::CMD_STOP);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain         <= sprp_pkg::PROP_GAIN_RST;
            r_cfg.integ_gain        <= sprp_pkg::INTEG_GAIN_RST;
            r_cfg.speed_limit       <= sprp_pkg::SPEED_LIM_RST;
            r_cfg.prescale_div      <= sprp_pkg::PRESCALE_RST;
            r_cfg.half_period       <= sprp_pkg::HALF_PER_RST;
            r_cfg.torque_to_current <= sprp_pkg::KT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (sprp_pkg::t_cfg_idx'(i_cfg_index))
                sprp_pkg::REG_PROP_GAIN:  r_cfg.prop_gain    <= i_cfg_data[sprp_pkg::GAIN_W-1:0];
                sprp_pkg::REG_INTEG_GAIN: r_cfg.integ_gain   <= i_cfg_data[sprp_pkg::GAIN_W-1:0];
                sprp_pkg::REG_SPEED_LIM:  r_cfg.speed_limit  <= i_cfg_data[sprp_pkg::LIM_W-1:0];
                sprp_pkg::REG_PRESCALE:   r_cfg.prescale_div <= i_cfg_data[sprp_pkg::DIV_W-1:0];
                sprp_pkg::REG_HALF_PER:   r_cfg.half_period  <= i_cfg_data[sprp_pkg::HP_W-1:0];
                sprp_pkg::REG_KT: begin
                    r_cfg.torque_to_current <= i_cfg_data[sprp_pkg::KT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_tick      <= '0;
            r_pending   <= 1'b0;
            r_upd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_upd <= w_run;
                case (w_cmd)
                    sprp_pkg::CMD_TICK: begin
                        r_tick    <= w_fire ? '0 : w_tick_next[sprp_pkg::DIV_W-1:0];
                        r_pending <= w_pend_after && !w_run;
                    end
                    sprp_pkg::CMD_START: begin
                        r_enabled <= 1'b1;
                    end
                    sprp_pkg::CMD_STOP: begin
                        r_enabled <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (w_stat.emit && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.emit && w_out_free) begin
            r_out_cur <= w_core_cur;
            r_out_err <= w_core_err;
            r_out_upd <= r_upd;
        end
    end

    sprp_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (w_req),
        .i_cfg            (r_cfg),
        .i_speed_ref      (i_s_tdata[31:0]),
        .i_measured_speed (i_s_tdata[63:32]),
        .i_out_free       (w_out_free),
        .o_stat           (w_stat),
        .o_current_ref    (w_core_cur),
        .o_speed_error    (w_core_err)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_err, r_out_cur};
    assign o_m_tuser  = r_out_upd;

endmodule

FILE: design/sprp_core.sv
// ----------------------------------------------------------------------------
// Speed PI regulator core
// Microcoded sequencer driving one shared multiplier, accumulator and
// saturating adders that run the clamp, integral and gain chain.
// ----------------------------------------------------------------------------
module sprp_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sprp_pkg::t_core_req                   i_req,
    input  sprp_pkg::t_cfg                        i_cfg,
    input  logic signed [sprp_pkg::SPEED_W-1:0]   i_speed_ref,
    input  logic signed [sprp_pkg::SPEED_W-1:0]   i_measured_speed,
    input  logic                                  i_out_free,
    output sprp_pkg::t_core_stat                  o_stat,
    output logic signed [sprp_pkg::SPEED_W-1:0]   o_current_ref,
    output logic signed [sprp_pkg::ERR_W-1:0]     o_speed_error
);

    sprp_pkg::t_upc   r_pc;
    sprp_pkg::t_upc   n_pc;
    logic             r_chunk;
    sprp_pkg::t_uword w_ctrl;

    logic signed [sprp_pkg::SPEED_W-1:0] r_ref;
    logic signed [sprp_pkg::SPEED_W-1:0] r_meas;
    logic signed [sprp_pkg::ERR_W-1:0]   r_err;
    logic signed [sprp_pkg::ERR_W-1:0]   r_prev;
    logic signed [sprp_pkg::INT_W-1:0]   r_int;
    logic signed [sprp_pkg::INT_W-1:0]   r_torque;
    logic signed [sprp_pkg::P_W-1:0]     r_p;
    logic signed [sprp_pkg::SPEED_W-1:0] r_held;
    logic [sprp_pkg::OPA_W-1:0]          r_opa;
    logic [sprp_pkg::OPB_W-1:0]          r_opb;
    logic                                r_neg;
    logic [sprp_pkg::ACC_W-1:0]          r_acc;
    logic [sprp_pkg::MAG_W-1:0]          r_mag;

    logic signed [sprp_pkg::ERR_W-1:0]   w_lim;
    logic signed [sprp_pkg::ERR_W-1:0]   w_nlim;
    logic signed [sprp_pkg::ERR_W-1:0]   w_ref;
    logic signed [sprp_pkg::ERR_W-1:0]   w_clamped;
    logic signed [sprp_pkg::ERR_W-1:0]   w_err;
    logic signed [sprp_pkg::SUM_W-1:0]   w_sum;
    logic [sprp_pkg::SUM_W-1:0]          w_sum_abs;
    logic [sprp_pkg::ERR_W-1:0]          w_err_abs;
    logic [sprp_pkg::INT_W-1:0]          w_int_abs;
    logic [sprp_pkg::INT_W-1:0]          w_torq_abs;
    logic [sprp_pkg::KT_W-1:0]           w_kt_abs;
    logic [sprp_pkg::CHUNK_W-1:0]        w_chunk;
    logic [sprp_pkg::PROD_W-1:0]         w_prod;
    logic [sprp_pkg::ACC_W-1:0]          w_acc_next;
    logic [sprp_pkg::ACC_W-1:0]          w_rnd_sum;
    logic [sprp_pkg::MAG_W-1:0]          w_rnd_mag;
    logic signed [sprp_pkg::SMAG_W-1:0]  w_mag_s;
    logic signed [sprp_pkg::SMAG_W-1:0]  w_smag;
    logic signed [sprp_pkg::WIDE_W-1:0]  w_int_sum;
    logic signed [sprp_pkg::WIDE_W-1:0]  w_torq_sum;

    assign w_ctrl = sprp_pkg::ucode_rom(r_pc);

    always_comb begin
        n_pc = r_pc + 1'b1;
        case (w_ctrl.cond)
            sprp_pkg::UC_NEXT: begin
                n_pc = r_pc + 1'b1;
            end
            sprp_pkg::UC_WAIT_GO: begin
                if (!i_req.go) begin
                    n_pc = r_pc;
                end else if (i_req.run) begin
                    n_pc = r_pc + 1'b1;
                end else begin
                    n_pc = w_ctrl.target;
                end
            end
            sprp_pkg::UC_CHUNK: begin
                n_pc = r_chunk ? r_pc + 1'b1 : r_pc;
            end
            sprp_pkg::UC_WAIT_OUT: begin
                n_pc = i_out_free ? w_ctrl.target : r_pc;
            end
            default: begin
                n_pc = sprp_pkg::UPC_IDLE;
            end
        endcase
    end

    assign w_lim     = {2'b00, i_cfg.speed_limit};
    assign w_nlim    = -w_lim;
    assign w_ref     = {r_ref[sprp_pkg::SPEED_W-1], r_ref};
    assign w_clamped = (w_ref > w_lim) ? w_lim : ((w_ref < w_nlim) ? w_nlim : w_ref);
    assign w_err     = w_clamped - {r_meas[sprp_pkg::SPEED_W-1], r_meas};

    assign w_sum      = {r_err[sprp_pkg::ERR_W-1], r_err} + {r_prev[sprp_pkg::ERR_W-1], r_prev};
    assign w_sum_abs  = w_sum[sprp_pkg::SUM_W-1] ? -w_sum : w_sum;
    assign w_err_abs  = r_err[sprp_pkg::ERR_W-1] ? -r_err : r_err;
    assign w_int_abs  = r_int[sprp_pkg::INT_W-1] ? -r_int : r_int;
    assign w_torq_abs = r_torque[sprp_pkg::INT_W-1] ? -r_torque : r_torque;
    assign w_kt_abs   = i_cfg.torque_to_current[sprp_pkg::KT_W-1] ?
                        -i_cfg.torque_to_current : i_cfg.torque_to_current;

    // The upper half of the second operand goes first, then the lower half.
    assign w_chunk    = r_chunk ? r_opb[sprp_pkg::CHUNK_W-1:0]
                                : r_opb[sprp_pkg::OPB_W-1:sprp_pkg::CHUNK_W];
    assign w_prod     = r_opa * w_chunk;
    assign w_acc_next = r_chunk ?
        ({r_acc[sprp_pkg::ACC_W-sprp_pkg::CHUNK_W-1:0], {sprp_pkg::CHUNK_W{1'b0}}} +
         {{(sprp_pkg::ACC_W-sprp_pkg::PROD_W){1'b0}}, w_prod}) :
        {{(sprp_pkg::ACC_W-sprp_pkg::PROD_W){1'b0}}, w_prod};

    assign w_rnd_sum = r_acc + ((w_ctrl.op == sprp_pkg::OP_RND32) ?
                                sprp_pkg::RND32_K : sprp_pkg::RND16_K);
    assign w_rnd_mag = (w_ctrl.op == sprp_pkg::OP_RND32) ?
                       {16'd0, w_rnd_sum[sprp_pkg::ACC_W-1:32]} :
                       w_rnd_sum[sprp_pkg::ACC_W-1:16];

    assign w_mag_s    = {1'b0, r_mag};
    assign w_smag     = r_neg ? -w_mag_s : w_mag_s;
    assign w_int_sum  = {{(sprp_pkg::WIDE_W-sprp_pkg::INT_W){r_int[sprp_pkg::INT_W-1]}}, r_int} +
                        {w_smag[sprp_pkg::SMAG_W-1], w_smag};
    assign w_torq_sum = {{(sprp_pkg::WIDE_W-sprp_pkg::P_W){r_p[sprp_pkg::P_W-1]}}, r_p} +
                        {w_smag[sprp_pkg::SMAG_W-1], w_smag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= sprp_pkg::UPC_IDLE;
            r_chunk <= 1'b0;
            r_int   <= '0;
            r_prev  <= '0;
            r_held  <= '0;
        end else begin
            r_pc    <= n_pc;
            r_chunk <= (w_ctrl.op == sprp_pkg::OP_MUL) ? ~r_chunk : 1'b0;
            if (w_ctrl.op == sprp_pkg::OP_IDLE && i_req.go && i_req.clr_int) begin
                r_int <= '0;
            end else if (w_ctrl.op == sprp_pkg::OP_INTEG) begin
                r_int  <= sprp_pkg::sat48(w_int_sum);
                r_prev <= r_err;
            end
            if (w_ctrl.op == sprp_pkg::OP_CUR) begin
                r_held <= sprp_pkg::sat32(w_smag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (w_ctrl.op)
            sprp_pkg::OP_IDLE: begin
                if (i_req.go) begin
                    r_ref  <= i_speed_ref;
                    r_meas <= i_measured_speed;
                end
            end
            sprp_pkg::OP_ERR: begin
                r_err <= w_err;
            end
            sprp_pkg::OP_LD_INC: begin
                r_opa <= w_sum_abs;
                r_opb <= {16'd0, i_cfg.half_period};
                r_neg <= w_sum[sprp_pkg::SUM_W-1];
            end
            sprp_pkg::OP_MUL: begin
                r_acc <= w_acc_next;
            end
            sprp_pkg::OP_RND32, sprp_pkg::OP_RND16: begin
                r_mag <= w_rnd_mag;
            end
            sprp_pkg::OP_INTEG: begin
                r_opa <= {10'd0, i_cfg.prop_gain};
                r_opb <= {15'd0, w_err_abs};
                r_neg <= r_err[sprp_pkg::ERR_W-1];
            end
            sprp_pkg::OP_PSAVE: begin
                r_p   <= w_smag[sprp_pkg::P_W-1:0];
                r_opa <= {10'd0, i_cfg.integ_gain};
                r_opb <= w_int_abs;
                r_neg <= r_int[sprp_pkg::INT_W-1];
            end
            sprp_pkg::OP_TORQ: begin
                r_torque <= sprp_pkg::sat48(w_torq_sum);
            end
            sprp_pkg::OP_LD_CUR: begin
                r_opa <= {10'd0, w_kt_abs};
                r_opb <= w_torq_abs;
                r_neg <= i_cfg.torque_to_current[sprp_pkg::KT_W-1] ^
                         r_torque[sprp_pkg::INT_W-1];
            end
            default: begin
            end
        endcase
    end

    assign o_stat.idle    = (w_ctrl.op == sprp_pkg::OP_IDLE);
    assign o_stat.emit    = (w_ctrl.op == sprp_pkg::OP_EMIT);
    assign o_current_ref  = r_held;
    assign o_speed_error  = r_prev;

`include "speed_pi_regulator_prescaled_top_assert.svh"

    `SPRP_ASSERT_IMPLY(a_chunk_in_mul, i_clk, i_rst_n, r_chunk, w_ctrl.op == sprp_pkg::OP_MUL)
    `SPRP_ASSERT_IMPLY(a_inc_fits, i_clk, i_rst_n, w_ctrl.op == sprp_pkg::OP_INTEG, r_mag[sprp_pkg::MAG_W-1:sprp_pkg::SUM_W] == '0)
    `SPRP_ASSERT_NEXT(a_run_starts, i_clk, i_rst_n, o_stat.idle && i_req.go && i_req.run, r_pc == sprp_pkg::UPC_ERR)
    `SPRP_ASSERT_NEXT(a_emit_leaves, i_clk, i_rst_n, o_stat.emit && i_out_free, r_pc == sprp_pkg::UPC_IDLE)

endmodule
